// ----- rtl/core/sorted_priority_queue_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared property shapes for the queue checker.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command and status codes, payload types and sequencer states.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  in_priority;
        logic [15:0] in_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_priority;
        logic [15:0] out_tag;
        logic [4:0]  held_count;
        logic        is_empty;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  priority_val;
        logic [15:0] tag;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENQ_CMP,
        S_ENQ_PUT,
        S_DEQ_RD
    } t_state;

endpackage

// ----- rtl/core/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of priority/tag entries, lowest priority value leaves first.
// ---------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start; the transfer happens at an edge where busy
//   is low. cmd selects enqueue or dequeue. Every transfer yields exactly one
//   result on o_result, shown for one cycle with o_result_strobe high.
//   Entries sit in a circular buffer in one RAM; the head pointer moves on
//   dequeue, so a dequeue costs one RAM read, and its registered read data
//   is returned through the result register. An enqueue walks backward from
//   the tail with one shared priority compare and one RAM read plus one
//   write per cycle, moving each entry of larger priority up one slot, then
//   drops the new entry into the gap; at most DEPTH-1 entries are moved.
//   An enqueue into a full queue or a dequeue from an empty one is answered
//   the cycle after the transfer without going busy.
//   A new item may start in the cycle its predecessor's result is shown.
//   Synchronous reset empties the queue; RAM contents are not cleared and
//   need not be, since only written slots are ever read.
//   The receiver cannot stall: results are not held.
// ---------------------------------------------------------------------------
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_result_strobe,
    output t_out_item o_result
);

    localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Sequencer and queue state
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_k, n_k;       // logical slot of the current gap
    t_entry           r_new, n_new;   // entry being inserted
    logic             r_strobe, n_strobe;
    t_out_item        r_result, n_result;

    // RAM port controls
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_entry           w_wr_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_rd_data;

    // Map a logical position (0 = front) to a RAM address around the ring.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic t_out_item make_result(input logic [1:0] status,
                                              input t_entry ent,
                                              input logic [CNT_W-1:0] cnt);
        t_out_item   res;
        logic [31:0] cnt_x;
        cnt_x            = 32'(cnt);
        res.status       = status;
        res.out_priority = ent.priority_val;
        res.out_tag      = ent.tag;
        res.held_count   = cnt_x[4:0];
        res.is_empty     = (cnt == '0);
        return res;
    endfunction

    spq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_spq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_new    <= n_new;
        r_result <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_k       = r_k;
        n_new     = r_new;
        n_strobe  = 1'b0;
        n_result  = r_result;
        w_wr_en   = 1'b0;
        w_wr_addr = phys(r_head, r_k);
        w_wr_data = r_new;
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.cmd == CMD_ENQ) begin
                        if (r_count == FULL_COUNT) begin
                            // Drop the entry, report full
                            n_strobe = 1'b1;
                            n_result = make_result(ST_FULL, '0, r_count);
                        end else begin
                            n_new.priority_val = i_item.in_priority;
                            n_new.tag          = i_item.in_tag;
                            n_k                = r_count[IDX_W-1:0];
                            if (r_count == '0) begin
                                n_state = S_ENQ_PUT;
                            end else begin
                                // Fetch the tail entry for the first compare
                                w_rd_en   = 1'b1;
                                w_rd_addr = phys(r_head, r_count[IDX_W-1:0] - IDX_W'(1));
                                n_state   = S_ENQ_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_strobe = 1'b1;
                            n_result = make_result(ST_EMPTY, '0, r_count);
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = r_head;
                            n_state   = S_DEQ_RD;
                        end
                    end
                end
            end

            S_ENQ_CMP: begin
                // Read data holds the entry just below the gap
                if (r_new.priority_val < w_rd_data.priority_val) begin
                    // Move it up into the gap, advance the gap downward
                    w_wr_en   = 1'b1;
                    w_wr_data = w_rd_data;
                    n_k       = r_k - IDX_W'(1);
                    if (r_k == IDX_W'(1)) begin
                        n_state = S_ENQ_PUT;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = phys(r_head, r_k - IDX_W'(2));
                    end
                end else begin
                    // Equal or lower priority below: insert here
                    w_wr_en  = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                    n_strobe = 1'b1;
                    n_result = make_result(ST_OK, '0, r_count + CNT_W'(1));
                    n_state  = S_IDLE;
                end
            end

            S_ENQ_PUT: begin
                w_wr_en  = 1'b1;
                n_count  = r_count + CNT_W'(1);
                n_strobe = 1'b1;
                n_result = make_result(ST_OK, '0, r_count + CNT_W'(1));
                n_state  = S_IDLE;
            end

            S_DEQ_RD: begin
                // Return the front entry and advance the head
                n_head   = phys(r_head, IDX_W'(1));
                n_count  = r_count - CNT_W'(1);
                n_strobe = 1'b1;
                n_result = make_result(ST_OK, w_rd_data, r_count - CNT_W'(1));
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

// ----- rtl/core/spq_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/spq_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level properties of the queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module spq_checker
    import spq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input t_in_item  i_item,
    input logic      busy,
    input logic      o_result_strobe,
    input t_out_item o_result
);

    logic w_xfer;
    logic w_reject;
    logic w_no_entry;
    logic w_empty_deq;
    logic w_held_none;

    assign w_xfer      = start && !busy &&
                         (i_item.cmd == CMD_ENQ || i_item.cmd == CMD_DEQ);
    assign w_reject    = o_result_strobe && (o_result.status != ST_OK);
    assign w_no_entry  = (o_result.out_priority == 8'd0) && (o_result.out_tag == 16'd0);
    assign w_empty_deq = o_result_strobe && (o_result.status == ST_EMPTY);
    assign w_held_none = o_result.is_empty && (o_result.held_count == 5'd0);

    // A transfer either occupies the unit or is answered right away
    `SPQ_ASSERT_NEXT(a_xfer_answered, i_clk, i_rst_n, w_xfer, busy || o_result_strobe)

    // A result is shown only once the unit is free again
    `SPQ_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_result_strobe, !busy)

    // Rejected items carry no entry
    `SPQ_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, w_reject, w_no_entry)

    // An empty dequeue leaves the queue empty
    `SPQ_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, w_empty_deq, w_held_none)

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .i_item          (i_item),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_result        (o_result)
);
